>>> rtl/core/pbfs_pkg.sv
// Package: shared constants and types for the packed bit field store.
package pbfs_pkg;

  localparam int WORD_BITS  = 64;
  localparam int WORD_COUNT = 1024;
  localparam int OFF_W      = $clog2(WORD_BITS);
  localparam int IDX_W      = $clog2(WORD_COUNT);
  localparam int BANK_DEPTH = WORD_COUNT / 2;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);

  localparam int POS_W  = 16;
  localparam int FLEN_W = 7;
  localparam int VAL_W  = 64;
  localparam int LEN_W  = 17;

  localparam logic [LEN_W-1:0]  STORE_BITS = LEN_W'(WORD_BITS * WORD_COUNT);
  localparam logic [LEN_W-1:0]  LEN_RESET  = LEN_W'(65536);
  localparam logic [FLEN_W-1:0] FIELD_MAX  = FLEN_W'(VAL_W);

  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  typedef struct packed {
    logic              is_write;
    logic              err;
    logic              odd_start;
    logic [OFF_W-1:0]  off;
    logic [FLEN_W-1:0] flen;
  } field_ctl_t;

endpackage

>>> rtl/core/pbfs_if.sv
// Interfaces: request and response channels of the packed bit field store.
interface pbfs_req_if;
  import pbfs_pkg::*;
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [POS_W-1:0]  bit_pos;
  logic [FLEN_W-1:0] field_len;
  logic [VAL_W-1:0]  write_value;

  modport source (output valid, req_type, bit_pos, field_len, write_value, input ready);
  modport sink   (input valid, req_type, bit_pos, field_len, write_value, output ready);
endinterface

interface pbfs_rsp_if;
  import pbfs_pkg::*;
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] read_value;
  logic             range_error;

  modport source (output valid, read_value, range_error, input ready);
  modport sink   (input valid, read_value, range_error, output ready);
endinterface

>>> rtl/core/packed_bit_field_store_core.sv
// Top level: packed bit field store with even/odd word banks.
//
// A request on in_req reads or writes a field of 0 to 64 bits at any bit
// position; a field may straddle two adjacent 64-bit words. The words sit
// in two banks (even and odd word index), so both words of a field are
// read in the same cycle and written back together.
// Each transaction on in_req yields exactly one transaction on out_rsp:
// read_value (right-aligned field, zero for writes and errors) and
// range_error (field runs past the usable length or is longer than 64).
// The request is registered into the write-back stage (bank read and control),
// and its response into the output register, which out_rsp drains. A new
// request is taken only once the previous one has left the write-back stage.
// A response waits in the output register while out_rsp is stalled; the
// next request is still taken and held at its write-back stage until the
// output register frees.
// cfg_we/cfg_wdata set length_bits (reset 65536); write only when idle.
// After reset both banks are cleared word by word, during which in_req
// is not ready.
module packed_bit_field_store_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [pbfs_pkg::LEN_W-1:0]    cfg_wdata,
  pbfs_req_if.sink                      in_req,
  pbfs_rsp_if.source                    out_rsp
);
  import pbfs_pkg::*;

  logic [LEN_W-1:0]   length_r;
  logic               clr_done_r;
  logic [BANK_AW-1:0] clr_cnt_r;
  logic               busy_r;
  logic               out_valid_r;
  logic [VAL_W-1:0]   out_value_r;
  logic               out_err_r;
  field_ctl_t         ctl_r;
  logic [VAL_W-1:0]   wval_r;
  logic [BANK_AW-1:0] even_idx_r;
  logic [BANK_AW-1:0] odd_idx_r;

  logic               accept;
  logic               advance;
  logic [IDX_W-1:0]   word_idx;
  logic [BANK_AW-1:0] even_idx;
  logic [BANK_AW-1:0] odd_idx;
  logic [LEN_W-1:0]   usable;
  logic [LEN_W-1:0]   field_end;
  logic               req_err;
  field_ctl_t         ctl_nxt;

  logic [VAL_W-1:0]   even_q;
  logic [VAL_W-1:0]   odd_q;
  logic [VAL_W-1:0]   lo_word;
  logic [VAL_W-1:0]   hi_word;
  logic [VAL_W-1:0]   rd_value;
  logic [VAL_W-1:0]   new_lo;
  logic [VAL_W-1:0]   new_hi;

  logic               store_we;
  logic               bank_we;
  logic [BANK_AW-1:0] even_waddr;
  logic [BANK_AW-1:0] odd_waddr;
  logic [VAL_W-1:0]   even_wdata;
  logic [VAL_W-1:0]   odd_wdata;

  assign in_req.ready = clr_done_r && !busy_r;
  assign accept       = in_req.valid && in_req.ready;
  assign advance      = busy_r && (!out_valid_r || out_rsp.ready);

  always_comb begin
    word_idx  = in_req.bit_pos[POS_W-1:OFF_W];
    odd_idx   = word_idx[IDX_W-1:1];
    even_idx  = word_idx[IDX_W-1:1] + BANK_AW'(word_idx[0]);
    usable    = (length_r > STORE_BITS) ? STORE_BITS : length_r;
    field_end = LEN_W'(in_req.bit_pos) + LEN_W'(in_req.field_len);
    req_err   = (in_req.field_len > FIELD_MAX) || (field_end > usable);
    ctl_nxt.is_write  = (in_req.req_type == REQ_WRITE);
    ctl_nxt.err       = req_err;
    ctl_nxt.odd_start = word_idx[0];
    ctl_nxt.off       = in_req.bit_pos[OFF_W-1:0];
    ctl_nxt.flen      = in_req.field_len;
  end

  pbfs_ram #(.WIDTH(VAL_W), .DEPTH(BANK_DEPTH)) u_even_bank (
    .clk   (clk),
    .we    (bank_we),
    .waddr (even_waddr),
    .wdata (even_wdata),
    .re    (accept),
    .raddr (even_idx),
    .rdata (even_q)
  );

  pbfs_ram #(.WIDTH(VAL_W), .DEPTH(BANK_DEPTH)) u_odd_bank (
    .clk   (clk),
    .we    (bank_we),
    .waddr (odd_waddr),
    .wdata (odd_wdata),
    .re    (accept),
    .raddr (odd_idx),
    .rdata (odd_q)
  );

  assign lo_word = ctl_r.odd_start ? odd_q : even_q;
  assign hi_word = ctl_r.odd_start ? even_q : odd_q;

  pbfs_field_unit u_field (
    .ctl      (ctl_r),
    .lo_word  (lo_word),
    .hi_word  (hi_word),
    .wval     (wval_r),
    .rd_value (rd_value),
    .new_lo   (new_lo),
    .new_hi   (new_hi)
  );

  always_comb begin
    store_we   = advance && ctl_r.is_write && !ctl_r.err;
    bank_we    = store_we || !clr_done_r;
    even_waddr = clr_done_r ? even_idx_r : clr_cnt_r;
    odd_waddr  = clr_done_r ? odd_idx_r : clr_cnt_r;
    if (!clr_done_r) begin
      even_wdata = '0;
      odd_wdata  = '0;
    end else begin
      even_wdata = ctl_r.odd_start ? new_hi : new_lo;
      odd_wdata  = ctl_r.odd_start ? new_lo : new_hi;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_r    <= LEN_RESET;
      clr_done_r  <= 1'b0;
      clr_cnt_r   <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        length_r <= cfg_wdata;
      end
      if (!clr_done_r) begin
        clr_cnt_r <= clr_cnt_r + BANK_AW'(1);
        if (clr_cnt_r == BANK_AW'(BANK_DEPTH - 1)) begin
          clr_done_r <= 1'b1;
        end
      end
      if (accept) begin
        busy_r <= 1'b1;
      end else if (advance) begin
        busy_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ctl_r      <= ctl_nxt;
      wval_r     <= in_req.write_value;
      even_idx_r <= even_idx;
      odd_idx_r  <= odd_idx;
    end
    if (advance) begin
      out_value_r <= rd_value;
      out_err_r   <= ctl_r.err;
    end
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.read_value  = out_value_r;
  assign out_rsp.range_error = out_err_r;

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> clr_done_r)
    else $error("request taken while banks are being cleared");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy_r)
    else $error("accepted request not held in write-back stage");

  a_free_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !out_valid_r) |=> (!busy_r && out_valid_r))
    else $error("write-back stage stalled with free output register");

  a_store_write_gated: assert property (@(posedge clk) disable iff (!rst_n)
    store_we |-> (clr_done_r && busy_r && !ctl_r.err))
    else $error("bank written outside an accepted in-range write");

endmodule

>>> rtl/core/pbfs_ram.sv
// Generic single-port-write, registered-read RAM.
module pbfs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/pbfs_field_unit.sv
// Field unit: extracts a field from a word pair and merges a write into it.
module pbfs_field_unit (
  input  pbfs_pkg::field_ctl_t         ctl,
  input  logic [pbfs_pkg::VAL_W-1:0]   lo_word,
  input  logic [pbfs_pkg::VAL_W-1:0]   hi_word,
  input  logic [pbfs_pkg::VAL_W-1:0]   wval,
  output logic [pbfs_pkg::VAL_W-1:0]   rd_value,
  output logic [pbfs_pkg::VAL_W-1:0]   new_lo,
  output logic [pbfs_pkg::VAL_W-1:0]   new_hi
);
  import pbfs_pkg::*;

  logic [VAL_W-1:0]   mask;
  logic [2*VAL_W-1:0] pair;
  logic [2*VAL_W-1:0] shifted;
  logic [2*VAL_W-1:0] m_pair;
  logic [2*VAL_W-1:0] v_pair;
  logic [2*VAL_W-1:0] merged;

  always_comb begin
    if (ctl.flen >= FIELD_MAX) begin
      mask = '1;
    end else begin
      mask = (VAL_W'(1) << ctl.flen[OFF_W-1:0]) - VAL_W'(1);
    end
    pair    = {hi_word, lo_word};
    shifted = pair >> ctl.off;
    m_pair  = {{VAL_W{1'b0}}, mask} << ctl.off;
    v_pair  = {{VAL_W{1'b0}}, wval & mask} << ctl.off;
    merged  = (pair & ~m_pair) | v_pair;
    new_lo  = merged[VAL_W-1:0];
    new_hi  = merged[2*VAL_W-1:VAL_W];
    if (ctl.is_write || ctl.err) begin
      rd_value = '0;
    end else begin
      rd_value = shifted[VAL_W-1:0] & mask;
    end
  end

endmodule

>>> dv/tb.sv
// Testbench for the packed bit field store: mirrored store, scoreboard and stimulus.
`timescale 1ns / 100ps

typedef struct packed {
  logic [pbfs_pkg::VAL_W-1:0] value;
  logic                       err;
} field_reply_t;

class field_store_mirror;
  logic [pbfs_pkg::WORD_BITS-1:0] words [pbfs_pkg::WORD_COUNT];
  logic [pbfs_pkg::LEN_W-1:0]     length_bits;
  field_reply_t                   replies_q [$];
  int                             failures;
  int                             reads;
  int                             writes;
  int                             rejects;

  function new();
    foreach (words[i]) words[i] = '0;
    length_bits = pbfs_pkg::LEN_RESET;
    failures = 0;
    reads = 0;
    writes = 0;
    rejects = 0;
  endfunction

  function void set_length(logic [pbfs_pkg::LEN_W-1:0] v);
    length_bits = v;
  endfunction

  function int unsigned usable_bits();
    if (length_bits > pbfs_pkg::STORE_BITS) return 32'(pbfs_pkg::STORE_BITS);
    return 32'(length_bits);
  endfunction

  function int pending();
    return replies_q.size();
  endfunction

  function void note_access(logic is_wr, logic [pbfs_pkg::POS_W-1:0] pos,
                            logic [pbfs_pkg::FLEN_W-1:0] flen,
                            logic [pbfs_pkg::VAL_W-1:0] wval);
    int unsigned  p;
    field_reply_t r;
    r.value = '0;
    r.err   = 1'b0;
    if (flen > pbfs_pkg::FIELD_MAX || int'(pos) + int'(flen) > int'(usable_bits())) begin
      r.err = 1'b1;
      rejects++;
    end else begin
      for (int i = 0; i < int'(flen); i++) begin
        p = int'(pos) + i;
        if (is_wr == pbfs_pkg::REQ_WRITE)
          words[p / pbfs_pkg::WORD_BITS][p % pbfs_pkg::WORD_BITS] = wval[i];
        else
          r.value[i] = words[p / pbfs_pkg::WORD_BITS][p % pbfs_pkg::WORD_BITS];
      end
      if (is_wr == pbfs_pkg::REQ_WRITE) writes++;
      else reads++;
    end
    replies_q.push_back(r);
  endfunction

  function void check_reply(logic [pbfs_pkg::VAL_W-1:0] val, logic err);
    field_reply_t exp_r;
    if (replies_q.size() == 0) begin
      $display("%0t: reply with none outstanding: read_value %h range_error %b",
               $time, val, err);
      failures++;
      return;
    end
    exp_r = replies_q.pop_front();
    if (val !== exp_r.value) begin
      $display("%0t: read_value mismatch: expected %h actual %h", $time, exp_r.value, val);
      failures++;
    end
    if (err !== exp_r.err) begin
      $display("%0t: range_error mismatch: expected %b actual %b", $time, exp_r.err, err);
      failures++;
    end
  endfunction
endclass

module tb;
  import pbfs_pkg::*;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [LEN_W-1:0] cfg_wdata;

  pbfs_req_if req_if ();
  pbfs_rsp_if rsp_if ();

  field_store_mirror mirror;

  int stall_pct;
  int hold_req;
  int hold_left;
  int run_left;
  int settings_done;

  packed_bit_field_store_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_req    (req_if),
    .out_rsp   (rsp_if)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #2_000_000;
    $display("%0t: timeout", $time);
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) mirror.set_length(cfg_wdata);
      if (req_if.valid && req_if.ready)
        mirror.note_access(req_if.req_type, req_if.bit_pos, req_if.field_len,
                           req_if.write_value);
      if (rsp_if.valid && rsp_if.ready)
        mirror.check_reply(rsp_if.read_value, rsp_if.range_error);
    end
  end

  // response-side back-pressure: random stall runs plus one long hold-off
  always @(negedge clk) begin
    logic rdy;
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      rdy = 1'b0;
      hold_left--;
    end else if (run_left > 0) begin
      rdy = 1'b0;
      run_left--;
    end else if ($urandom_range(99) < stall_pct) begin
      rdy = 1'b0;
      run_left = $urandom_range(0, 4);
    end else begin
      rdy = 1'b1;
    end
    rsp_if.ready <= rdy;
  end

  task automatic send_access(input logic is_wr, input logic [POS_W-1:0] pos,
                             input logic [FLEN_W-1:0] flen, input logic [VAL_W-1:0] wval);
    @(negedge clk);
    req_if.valid       <= 1'b1;
    req_if.req_type    <= is_wr;
    req_if.bit_pos     <= pos;
    req_if.field_len   <= flen;
    req_if.write_value <= wval;
    do @(posedge clk); while (!req_if.ready);
  endtask

  task automatic idle_in(input int n);
    repeat (n) begin
      @(negedge clk);
      req_if.valid <= 1'b0;
    end
  endtask

  task automatic wait_drained();
    idle_in(1);
    while (mirror.pending() != 0) @(posedge clk);
  endtask

  task automatic write_length(input logic [LEN_W-1:0] v);
    wait_drained();
    repeat (3) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    settings_done++;
  endtask

  task automatic pick_access(input int unsigned hot_base, output logic is_wr,
                             output logic [POS_W-1:0] pos, output logic [FLEN_W-1:0] flen,
                             output logic [VAL_W-1:0] wval);
    int sel;
    int tmp;
    is_wr = 1'($urandom_range(1));
    sel = $urandom_range(19);
    if (sel < 10)      flen = FLEN_W'($urandom_range(1, 64));
    else if (sel < 13) flen = FIELD_MAX;
    else if (sel < 15) flen = FLEN_W'(1);
    else if (sel < 16) flen = '0;
    else if (sel < 18) flen = FLEN_W'($urandom_range(65, 127));
    else               flen = FLEN_W'($urandom_range(2, 8));
    sel = $urandom_range(9);
    if (sel < 7) begin
      pos = POS_W'(hot_base + $urandom_range(0, 255));
    end else if (sel < 8) begin
      pos = POS_W'($urandom_range(0, 65535));
    end else begin
      tmp = int'(mirror.usable_bits()) - int'(flen) + int'($urandom_range(0, 3)) - 2;
      if (tmp < 0) tmp = $urandom_range(0, 3);
      if (tmp > 65535) tmp = 65535 - $urandom_range(0, 3);
      pos = POS_W'(tmp);
    end
    sel = $urandom_range(7);
    if (sel == 0)      wval = '1;
    else if (sel == 1) wval = '0;
    else               wval = {$urandom, $urandom};
  endtask

  task automatic run_phase(input int n_items, input int max_gap, input int unsigned hot_base,
                           input int mid_drain);
    logic             is_wr;
    logic [POS_W-1:0] pos;
    logic [FLEN_W-1:0] flen;
    logic [VAL_W-1:0] wval;
    int               k;
    int               burst;
    k = 0;
    while (k < n_items) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst && k < n_items; b++) begin
        pick_access(hot_base, is_wr, pos, flen, wval);
        send_access(is_wr, pos, flen, wval);
        k++;
        if (mid_drain != 0 && k == n_items / 2) wait_drained();
      end
      if (max_gap > 0) idle_in($urandom_range(0, max_gap));
    end
  endtask

  task automatic run_directed();
    send_access(REQ_READ,  16'd0,     7'd0,  64'h0);
    send_access(REQ_WRITE, 16'd0,     7'd64, '1);
    send_access(REQ_READ,  16'd0,     7'd64, 64'h0);
    send_access(REQ_WRITE, 16'd60,    7'd10, 64'h2AA);
    send_access(REQ_READ,  16'd56,    7'd20, 64'h0);
    send_access(REQ_WRITE, 16'd200,   7'd0,  '1);
    send_access(REQ_READ,  16'd196,   7'd12, 64'h0);
    send_access(REQ_WRITE, 16'd127,   7'd2,  64'h3);
    send_access(REQ_READ,  16'd126,   7'd4,  64'h0);
    send_access(REQ_WRITE, 16'd300,   7'd1,  64'h1);
    send_access(REQ_READ,  16'd300,   7'd1,  64'h0);
    send_access(REQ_WRITE, 16'd300,   7'd1,  64'h0);
    send_access(REQ_READ,  16'd299,   7'd3,  64'h0);
    send_access(REQ_WRITE, 16'd65472, 7'd64, 64'hDEAD_BEEF_0123_4567);
    send_access(REQ_READ,  16'd65472, 7'd64, 64'h0);
    send_access(REQ_WRITE, 16'd65535, 7'd1,  64'h1);
    send_access(REQ_READ,  16'd65535, 7'd1,  64'h0);
    send_access(REQ_READ,  16'd65535, 7'd0,  64'h0);
    send_access(REQ_READ,  16'd65500, 7'd64, 64'h0);
    send_access(REQ_WRITE, 16'd65535, 7'd2,  '1);
    send_access(REQ_WRITE, 16'd100,   7'd65, '1);
    send_access(REQ_READ,  16'd0,     7'd127, 64'h0);
    send_access(REQ_WRITE, 16'd1,     7'd63, 64'h0);
    send_access(REQ_READ,  16'd0,     7'd64, 64'h0);
  endtask

  initial begin
    int unsigned rl;
    int unsigned base;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    req_if.valid       = 1'b0;
    req_if.req_type    = REQ_READ;
    req_if.bit_pos     = '0;
    req_if.field_len   = '0;
    req_if.write_value = '0;
    rsp_if.ready       = 1'b0;
    stall_pct          = 20;
    hold_req           = 0;
    hold_left          = 0;
    run_left           = 0;
    settings_done      = 1;
    mirror             = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_directed();

    write_length(17'd65536);
    hold_req = 300;
    run_phase(80, 6, 0, 0);

    write_length(17'h1FFFF);
    stall_pct = 0;
    run_phase(70, 0, 65280, 0);

    write_length(17'd1000);
    stall_pct = 50;
    run_phase(60, 4, 800, 1);

    write_length(17'd0);
    stall_pct = 30;
    run_phase(20, 3, 0, 0);

    write_length(17'd64);
    run_phase(30, 2, 0, 0);

    write_length(17'd65535);
    stall_pct = 40;
    run_phase(70, 8, 65280, 0);

    rl = $urandom_range(1, 65536);
    base = (rl > 256) ? rl - 256 : 0;
    if (base > 65280) base = 65280;
    write_length(LEN_W'(rl));
    stall_pct = 25;
    run_phase(60, 5, base, 0);

    write_length(17'd65536);
    stall_pct = 15;
    run_phase(60, 3, 0, 0);

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Covered %0d reads, %0d writes and %0d rejected accesses", mirror.reads,
             mirror.writes, mirror.rejects);
    $display("across %0d length settings, with straddling fields and back-pressure",
             settings_done);
    if (mirror.failures == 0 && mirror.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
